// File: hw/rtl/cpq_pkg.sv
// Shared types and constants of the cylinder point query unit.
`default_nettype none
package cpq_pkg;
	localparam int SQ_STEPS = 34;
	localparam int QW       = 31;
	localparam int LANES    = 4;

	localparam logic [2:0] REG_RADIUS  = 3'd0;
	localparam logic [2:0] REG_HLOW    = 3'd1;
	localparam logic [2:0] REG_HHIGH   = 3'd2;
	localparam logic [2:0] REG_SHIFT_X = 3'd3;
	localparam logic [2:0] REG_SHIFT_Y = 3'd4;
	localparam logic [2:0] REG_SHIFT_Z = 3'd5;

	localparam logic [1:0] FACE_RADIAL = 2'd0;
	localparam logic [1:0] FACE_BOTTOM = 2'd1;
	localparam logic [1:0] FACE_TOP    = 2'd2;

	localparam logic signed [31:0] NORM_ONE = 32'sh4000_0000;
	localparam logic signed [31:0] NORM_NEG = 32'shC000_0000;

	typedef struct packed {
		logic [67:0] op;
		logic [34:0] rem;
		logic [33:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic               outside;
		logic               in_body;
		logic [63:0]        px;
		logic [63:0]        py;
	} sq_side_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic               outside;
		logic               in_body;
		logic [1:0]         face;
		logic [33:0]        root;
	} dv_side_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [30:0] num;
		logic [30:0] quo;
	} lane_t;
endpackage
`default_nettype wire

// File: hw/rtl/cpq_sqrt_cell.sv
// One digit step of the pipelined integer square root.
`default_nettype none
module cpq_sqrt_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              up_valid,
	input  wire cpq_pkg::sq_t      up_sq,
	input  wire cpq_pkg::sq_side_t up_side,
	output logic                   valid,
	output cpq_pkg::sq_t           sq,
	output cpq_pkg::sq_side_t      side
);
	logic [36:0] cat, trial;
	logic        ge;
	cpq_pkg::sq_t nxt;
	logic valid_q;
	cpq_pkg::sq_t sq_q;
	cpq_pkg::sq_side_t side_q;

	always_comb begin
		cat      = {up_sq.rem, up_sq.op[67:66]};
		trial    = {1'b0, up_sq.root, 2'b01};
		ge       = (cat >= trial);
		nxt.op   = {up_sq.op[65:0], 2'b00};
		nxt.rem  = ge ? 35'(cat - trial) : cat[34:0];
		nxt.root = {up_sq.root[32:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q   <= nxt;
			side_q <= up_side;
		end
	end

	assign valid = valid_q;
	assign sq    = sq_q;
	assign side  = side_q;
endmodule
`default_nettype wire

// File: hw/rtl/cpq_div_cell.sv
// One quotient bit of four restoring division lanes sharing one divisor.
`default_nettype none
module cpq_div_cell (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  up_valid,
	input  wire cpq_pkg::dv_side_t                     up_side,
	input  wire cpq_pkg::lane_t [cpq_pkg::LANES-1:0]   up_lane,
	output logic                                       valid,
	output cpq_pkg::dv_side_t                          side,
	output cpq_pkg::lane_t [cpq_pkg::LANES-1:0]        lane
);
	cpq_pkg::lane_t [cpq_pkg::LANES-1:0] nxt;
	cpq_pkg::lane_t [cpq_pkg::LANES-1:0] lane_q;
	cpq_pkg::dv_side_t side_q;
	logic valid_q;

	always_comb begin
		for (int i = 0; i < cpq_pkg::LANES; i++) begin
			logic [34:0] t;
			logic        ge;
			t  = {up_lane[i].rem, up_lane[i].num[30]};
			ge = (t >= {1'b0, up_side.root});
			nxt[i].rem = ge ? 34'(t - {1'b0, up_side.root}) : t[33:0];
			nxt[i].num = {up_lane[i].num[29:0], 1'b0};
			nxt[i].quo = {up_lane[i].quo[29:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
			side_q <= up_side;
		end
	end

	assign valid = valid_q;
	assign side  = side_q;
	assign lane  = lane_q;
endmodule
`default_nettype wire

// File: hw/rtl/cylinder_point_query_unit.sv
// Top level of the point query against a finite axis-aligned cylinder.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall  | point_x, point_y, point_z
//  out     | output    | out_valid / out_stall| is_inside, face_id, near_*, norm_*
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle enters while no stalled result holds the chain; each item passes through
// 70 registers: 3 front stages, 34 root cells, one face stage, 31 divider cells, the output.
// Most of the pipeline depth lies in the chain of square root and divider cells.
// Reset clears all valid bits and loads the register defaults; configuration is always ready.
// A stalled result freezes the whole chain, so in_stall follows out_stall while a result waits.
`default_nettype none
module cylinder_point_query_unit #(
	parameter int COORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] point_x,
	input  wire logic [31:0] point_y,
	input  wire logic [31:0] point_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             is_inside,
	output logic [1:0]       face_id,
	output logic [31:0]      near_x,
	output logic [31:0]      near_y,
	output logic [31:0]      near_z,
	output logic [31:0]      norm_x,
	output logic [31:0]      norm_y,
	output logic [31:0]      norm_z,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int CW = (COORD_BITS > 32) ? 32 : COORD_BITS;
	localparam logic signed [34:0] SAT_HI = (35'sd1 <<< (CW - 1)) - 35'sd1;
	localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

	function automatic logic signed [31:0] sext_cw(input logic [31:0] v);
		logic [31:0] o;
		for (int i = 0; i < 32; i++) o[i] = (i < CW) ? v[i] : v[CW-1];
		return $signed(o);
	endfunction

	function automatic logic [31:0] sat_cw(input logic signed [34:0] v);
		logic signed [34:0] s;
		s = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
		return s[31:0];
	endfunction

	// Configuration registers.
	logic [30:0]        radius_q;
	logic signed [31:0] hlow_q, hhigh_q, shx_q, shy_q, shz_q;
	logic [61:0]        rad2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 31'd65536;
			hlow_q   <= '0;
			hhigh_q  <= 32'sd65536;
			shx_q    <= '0;
			shy_q    <= '0;
			shz_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cpq_pkg::REG_RADIUS:  radius_q <= cfg_data[30:0];
				cpq_pkg::REG_HLOW:    hlow_q   <= sext_cw(cfg_data);
				cpq_pkg::REG_HHIGH:   hhigh_q  <= sext_cw(cfg_data);
				cpq_pkg::REG_SHIFT_X: shx_q    <= sext_cw(cfg_data);
				cpq_pkg::REG_SHIFT_Y: shy_q    <= sext_cw(cfg_data);
				cpq_pkg::REG_SHIFT_Z: shz_q    <= sext_cw(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rad2_q <= {31'b0, radius_q} * {31'b0, radius_q};
	end

	assign cfg_ready = 1'b1;

	logic en;
	logic out_valid_q;
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Stage 1: move the point into the cylinder frame.
	logic               valid_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [31:0] pxe, pye, pze;

	always_comb begin
		pxe = sext_cw(point_x);
		pye = sext_cw(point_y);
		pze = sext_cw(point_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({pxe[31], pxe}) - $signed({shx_q[31], shx_q});
			dy_s1 <= $signed({pye[31], pye}) - $signed({shy_q[31], shy_q});
			dz_s1 <= $signed({pze[31], pze}) - $signed({shz_q[31], shz_q});
		end
	end

	// Stage 2: squares and radius products.
	logic               valid_s2;
	logic signed [32:0] dx_s2, dy_s2, dz_s2;
	logic [65:0]        sx2_s2, sy2_s2;
	logic [63:0]        px_s2, py_s2;
	logic [32:0]        ax1, ay1;

	assign ax1 = dx_s1[32] ? 33'(-dx_s1) : dx_s1;
	assign ay1 = dy_s1[32] ? 33'(-dy_s1) : dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;
			sx2_s2 <= {33'b0, ax1} * {33'b0, ax1};
			sy2_s2 <= {33'b0, ay1} * {33'b0, ay1};
			px_s2  <= {31'b0, ax1} * {33'b0, radius_q};
			py_s2  <= {31'b0, ay1} * {33'b0, radius_q};
		end
	end

	// Stage 3: sum of squares, radial and height tests.
	logic              valid_s3;
	cpq_pkg::sq_t      sq_s3;
	cpq_pkg::sq_side_t side_s3;
	logic [65:0]       sum2;
	logic              outside2;

	always_comb begin
		sum2     = sx2_s2 + sy2_s2;
		outside2 = (sum2 > {4'b0, rad2_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3.op        <= {2'b00, sum2};
			sq_s3.rem       <= '0;
			sq_s3.root      <= '0;
			side_s3.dx      <= dx_s2;
			side_s3.dy      <= dy_s2;
			side_s3.dz      <= dz_s2;
			side_s3.outside <= outside2;
			side_s3.in_body <= !outside2 && (dz_s2 >= hlow_q) && (dz_s2 <= hhigh_q);
			side_s3.px      <= px_s2;
			side_s3.py      <= py_s2;
		end
	end

	// Square root chain.
	logic              sq_valid [0:cpq_pkg::SQ_STEPS];
	cpq_pkg::sq_t      sq_d     [0:cpq_pkg::SQ_STEPS];
	cpq_pkg::sq_side_t sq_side  [0:cpq_pkg::SQ_STEPS];

	assign sq_valid[0] = valid_s3;
	assign sq_d[0]     = sq_s3;
	assign sq_side[0]  = side_s3;

	for (genvar g = 0; g < cpq_pkg::SQ_STEPS; g++) begin : g_sqrt
		cpq_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (sq_valid[g]),
			.up_sq    (sq_d[g]),
			.up_side  (sq_side[g]),
			.valid    (sq_valid[g+1]),
			.sq       (sq_d[g+1]),
			.side     (sq_side[g+1])
		);
	end

	// Stage 4: closest face and divider setup.
	cpq_pkg::sq_side_t                 ss;
	logic [33:0]                       rt;
	logic signed [34:0]                d1s;
	logic signed [33:0]                d2s, d3s;
	logic [34:0]                       d1, d2, d3, mn, mn2;
	logic [1:0]                        face;
	logic [32:0]                       axf, ayf;
	logic                              valid_s4;
	cpq_pkg::dv_side_t                 dside_s4;
	cpq_pkg::lane_t [cpq_pkg::LANES-1:0] lane_s4;

	always_comb begin
		ss  = sq_side[cpq_pkg::SQ_STEPS];
		rt  = sq_d[cpq_pkg::SQ_STEPS].root;
		d1s = $signed({1'b0, rt}) - $signed({4'b0, radius_q});
		d2s = $signed({ss.dz[32], ss.dz}) - $signed({{2{hlow_q[31]}}, hlow_q});
		d3s = $signed({ss.dz[32], ss.dz}) - $signed({{2{hhigh_q[31]}}, hhigh_q});
		d1  = d1s[34] ? 35'(-d1s) : d1s;
		d2  = {1'b0, (d2s[33] ? 34'(-d2s) : d2s)};
		d3  = {1'b0, (d3s[33] ? 34'(-d3s) : d3s)};
		mn  = (d2 < d3) ? d2 : d3;
		mn2 = (d1 < d3) ? d1 : d3;
		if (d1 <= mn) face = cpq_pkg::FACE_RADIAL;
		else if (d2 <= mn2) face = cpq_pkg::FACE_BOTTOM;
		else face = cpq_pkg::FACE_TOP;
		axf = ss.dx[32] ? 33'(-ss.dx) : ss.dx;
		ayf = ss.dy[32] ? 33'(-ss.dy) : ss.dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else if (en) valid_s4 <= sq_valid[cpq_pkg::SQ_STEPS];
	end

	// The quotients stay below 2^31, so the top numerator bits start as the remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			dside_s4.dx      <= ss.dx;
			dside_s4.dy      <= ss.dy;
			dside_s4.dz      <= ss.dz;
			dside_s4.outside <= ss.outside;
			dside_s4.in_body <= ss.in_body;
			dside_s4.face    <= face;
			dside_s4.root    <= rt;
			lane_s4[0].rem   <= {1'b0, ss.px[63:31]};
			lane_s4[0].num   <= ss.px[30:0];
			lane_s4[1].rem   <= {1'b0, ss.py[63:31]};
			lane_s4[1].num   <= ss.py[30:0];
			lane_s4[2].rem   <= {2'b0, axf[32:1]};
			lane_s4[2].num   <= {axf[0], 30'b0};
			lane_s4[3].rem   <= {2'b0, ayf[32:1]};
			lane_s4[3].num   <= {ayf[0], 30'b0};
			for (int i = 0; i < cpq_pkg::LANES; i++) lane_s4[i].quo <= '0;
		end
	end

	// Divider chain.
	logic                                dv_valid [0:cpq_pkg::QW];
	cpq_pkg::dv_side_t                   dv_side  [0:cpq_pkg::QW];
	cpq_pkg::lane_t [cpq_pkg::LANES-1:0] dv_lane  [0:cpq_pkg::QW];

	assign dv_valid[0] = valid_s4;
	assign dv_side[0]  = dside_s4;
	assign dv_lane[0]  = lane_s4;

	for (genvar g = 0; g < cpq_pkg::QW; g++) begin : g_div
		cpq_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (dv_valid[g]),
			.up_side  (dv_side[g]),
			.up_lane  (dv_lane[g]),
			.valid    (dv_valid[g+1]),
			.side     (dv_side[g+1]),
			.lane     (dv_lane[g+1])
		);
	end

	// Output stage.
	cpq_pkg::dv_side_t  fs;
	logic [30:0]        qx, qy, qnx, qny;
	logic signed [34:0] nx, ny, nz, sx, sy, sz;
	logic signed [33:0] zc;
	logic signed [31:0] ox, oy, oz;

	always_comb begin
		fs  = dv_side[cpq_pkg::QW];
		qx  = dv_lane[cpq_pkg::QW][0].quo;
		qy  = dv_lane[cpq_pkg::QW][1].quo;
		qnx = (dv_lane[cpq_pkg::QW][2].quo > 31'h4000_0000) ? 31'h4000_0000
			: dv_lane[cpq_pkg::QW][2].quo;
		qny = (dv_lane[cpq_pkg::QW][3].quo > 31'h4000_0000) ? 31'h4000_0000
			: dv_lane[cpq_pkg::QW][3].quo;
		if (fs.outside) begin
			nx = fs.dx[32] ? -$signed({4'b0, qx}) : $signed({4'b0, qx});
			ny = fs.dy[32] ? -$signed({4'b0, qy}) : $signed({4'b0, qy});
		end else begin
			nx = {{2{fs.dx[32]}}, fs.dx};
			ny = {{2{fs.dy[32]}}, fs.dy};
		end
		zc = {fs.dz[32], fs.dz};
		if (fs.dz > hhigh_q) zc = {{2{hhigh_q[31]}}, hhigh_q};
		if (zc < $signed({{2{hlow_q[31]}}, hlow_q})) zc = {{2{hlow_q[31]}}, hlow_q};
		nz = {zc[33], zc};
		sx = nx + $signed({{3{shx_q[31]}}, shx_q});
		sy = ny + $signed({{3{shy_q[31]}}, shy_q});
		sz = nz + $signed({{3{shz_q[31]}}, shz_q});
		ox = '0;
		oy = '0;
		oz = '0;
		case (fs.face)
			cpq_pkg::FACE_BOTTOM: oz = cpq_pkg::NORM_NEG;
			cpq_pkg::FACE_TOP:    oz = cpq_pkg::NORM_ONE;
			default: begin
				// A point on the axis has no radial direction.
				if (fs.root != '0) begin
					ox = fs.dx[32] ? -$signed({1'b0, qnx}) : $signed({1'b0, qnx});
					oy = fs.dy[32] ? -$signed({1'b0, qny}) : $signed({1'b0, qny});
				end
			end
		endcase
	end

	logic        inside_q;
	logic [1:0]  face_q;
	logic [31:0] nearx_q, neary_q, nearz_q, normx_q, normy_q, normz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dv_valid[cpq_pkg::QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_q <= fs.in_body;
			face_q   <= fs.face;
			nearx_q  <= sat_cw(sx);
			neary_q  <= sat_cw(sy);
			nearz_q  <= sat_cw(sz);
			normx_q  <= ox;
			normy_q  <= oy;
			normz_q  <= oz;
		end
	end

	assign out_valid = out_valid_q;
	assign is_inside = inside_q;
	assign face_id   = face_q;
	assign near_x    = nearx_q;
	assign near_y    = neary_q;
	assign near_z    = nearz_q;
	assign norm_x    = normx_q;
	assign norm_y    = normy_q;
	assign norm_z    = normz_q;
endmodule
`default_nettype wire

// File: hw/rtl/cpq_checker.sv
// Port-level checks of the cylinder point query unit and their binding.
`default_nettype none
module cpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  face_id,
	input wire logic [31:0] near_x,
	input wire logic [31:0] norm_x,
	input wire logic [31:0] norm_y,
	input wire logic [31:0] norm_z
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(near_x) && $stable(face_id))
		else $error("stalled result changed");

	a_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && face_id == cpq_pkg::FACE_BOTTOM |->
			norm_z == cpq_pkg::NORM_NEG && norm_x == '0 && norm_y == '0)
		else $error("bottom normal wrong");

	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && face_id == cpq_pkg::FACE_TOP |->
			norm_z == cpq_pkg::NORM_ONE && norm_x == '0 && norm_y == '0)
		else $error("top normal wrong");

	a_radial: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> face_id != 2'd3 && (face_id != cpq_pkg::FACE_RADIAL || norm_z == '0))
		else $error("bad face or radial normal");
endmodule

bind cylinder_point_query_unit cpq_checker u_cpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.face_id   (face_id),
	.near_x    (near_x),
	.norm_x    (norm_x),
	.norm_y    (norm_y),
	.norm_z    (norm_z)
);
`default_nettype wire

// File: tb/cylinder_point_query_unit_tb.sv
// Self-checking testbench of the cylinder point query unit with a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module cylinder_point_query_unit_tb;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam longint UNIT_Q30 = 64'sd1073741824;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} point_t;

	typedef struct packed {
		logic        in_body;
		logic [1:0]  face;
		logic [31:0] near_x;
		logic [31:0] near_y;
		logic [31:0] near_z;
		logic [31:0] norm_x;
		logic [31:0] norm_y;
		logic [31:0] norm_z;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] point_x = '0;
	logic [31:0] point_y = '0;
	logic [31:0] point_z = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_inside;
	logic [1:0]  face_id;
	logic [31:0] near_x, near_y, near_z, norm_x, norm_y, norm_z;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	cylinder_point_query_unit u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Register copies used by the predictor.
	longint radius_q = 65536, hlow_q = 0, hhigh_q = 65536;
	longint shx_q = 0, shy_q = 0, shz_q = 0;

	point_t  pending_points[$];
	answer_t awaited_answers[$];
	int      errors = 0;
	bit      no_idle = 1'b0;
	bit      hold_req = 1'b0;
	bit      hold = 1'b0;
	bit      sending = 1'b0;

	function automatic longint quot_signed(longint s, logic [95:0] m, logic [33:0] d);
		logic [95:0] q;
		q = m / {62'd0, d};
		return (s < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic answer_t query_cylinder(point_t p);
		longint      dx, dy, dz, nx, ny, nz, d1, d2, d3, mn, ox, oy, oz, r;
		logic [65:0] ax, ay, r2, rad2;
		logic [67:0] t2;
		logic [33:0] rt, t;
		logic        outside;
		answer_t     a;
		dx = longint'(signed'(p.x)) - shx_q;
		dy = longint'(signed'(p.y)) - shy_q;
		dz = longint'(signed'(p.z)) - shz_q;
		ax = (dx < 0) ? 66'(-dx) : 66'(dx);
		ay = (dy < 0) ? 66'(-dy) : 66'(dy);
		r2 = ax * ax + ay * ay;
		rad2 = 66'(radius_q) * 66'(radius_q);
		outside = r2 > rad2;
		rt = '0;
		for (int b = 33; b >= 0; b--) begin
			t = rt | (34'd1 << b);
			t2 = {34'd0, t} * {34'd0, t};
			if (t2 <= {2'b00, r2}) rt = t;
		end
		r = longint'(rt);
		a.in_body = !outside && dz >= hlow_q && dz <= hhigh_q;
		nx = dx;
		ny = dy;
		nz = dz;
		if (nz > hhigh_q) nz = hhigh_q;
		if (nz < hlow_q) nz = hlow_q;
		if (outside) begin
			nx = quot_signed(dx, 96'(ax) * 96'(radius_q), rt);
			ny = quot_signed(dy, 96'(ay) * 96'(radius_q), rt);
		end
		a.near_x = sat32(nx + shx_q);
		a.near_y = sat32(ny + shy_q);
		a.near_z = sat32(nz + shz_q);
		d1 = (r > radius_q) ? r - radius_q : radius_q - r;
		d2 = (dz > hlow_q) ? dz - hlow_q : hlow_q - dz;
		d3 = (dz > hhigh_q) ? dz - hhigh_q : hhigh_q - dz;
		mn = (d2 < d3) ? d2 : d3;
		if (d1 <= mn) begin
			a.face = cpq_pkg::FACE_RADIAL;
		end else begin
			mn = (d1 < d3) ? d1 : d3;
			a.face = (d2 <= mn) ? cpq_pkg::FACE_BOTTOM : cpq_pkg::FACE_TOP;
		end
		ox = 0;
		oy = 0;
		oz = 0;
		if (a.face == cpq_pkg::FACE_BOTTOM) begin
			oz = -UNIT_Q30;
		end else if (a.face == cpq_pkg::FACE_TOP) begin
			oz = UNIT_Q30;
		end else if (rt != 0) begin
			ox = quot_signed(dx, 96'(ax) << 30, rt);
			oy = quot_signed(dy, 96'(ay) << 30, rt);
			if (ox > UNIT_Q30) ox = UNIT_Q30;
			if (ox < -UNIT_Q30) ox = -UNIT_Q30;
			if (oy > UNIT_Q30) oy = UNIT_Q30;
			if (oy < -UNIT_Q30) oy = -UNIT_Q30;
		end
		a.norm_x = ox[31:0];
		a.norm_y = oy[31:0];
		a.norm_z = oz[31:0];
		return a;
	endfunction

	// Sender: one item at a time with a random gap in front of each.
	int     send_gap = 0;
	point_t cur_point;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sending = 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				awaited_answers.push_back(query_cylinder(cur_point));
				sending = 1'b0;
				send_gap = no_idle ? 0 : $urandom_range(0, 14);
			end
			if (!sending) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_points.size() > 0) begin
					cur_point = pending_points.pop_front();
					sending = 1'b1;
					point_x <= cur_point.x;
					point_y <= cur_point.y;
					point_z <= cur_point.z;
				end
			end
			in_valid <= sending;
		end
	end

	// Receiver: random stall per result, plus the long hold-off.
	int      stall_left = 0;
	answer_t got, want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{is_inside, face_id, near_x, near_y, near_z, norm_x, norm_y, norm_z};
				if (awaited_answers.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %p", got);
				end else begin
					want = awaited_answers.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
					end
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 14);
			end
			out_stall <= hold || stall_left > 0;
			if (stall_left > 0) stall_left--;
		end
	end

	initial begin
		wait (hold_req);
		@(posedge clk);
		hold <= 1'b1;
		repeat (400) @(posedge clk);
		hold <= 1'b0;
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			cpq_pkg::REG_RADIUS:  radius_q = longint'(v[30:0]);
			cpq_pkg::REG_HLOW:    hlow_q = longint'(signed'(v));
			cpq_pkg::REG_HHIGH:   hhigh_q = longint'(signed'(v));
			cpq_pkg::REG_SHIFT_X: shx_q = longint'(signed'(v));
			cpq_pkg::REG_SHIFT_Y: shy_q = longint'(signed'(v));
			cpq_pkg::REG_SHIFT_Z: shz_q = longint'(signed'(v));
			default: ;
		endcase
	endtask

	task automatic set_cylinder(logic [31:0] rad, logic [31:0] lo, logic [31:0] hi,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
		write_reg(cpq_pkg::REG_RADIUS, rad);
		write_reg(cpq_pkg::REG_HLOW, lo);
		write_reg(cpq_pkg::REG_HHIGH, hi);
		write_reg(cpq_pkg::REG_SHIFT_X, sx);
		write_reg(cpq_pkg::REG_SHIFT_Y, sy);
		write_reg(cpq_pkg::REG_SHIFT_Z, sz);
	endtask

	// Signed offset of random magnitude, from tiny to max_w bits wide.
	function automatic logic [31:0] rand_span(int max_w);
		logic [31:0] v;
		int          w;
		w = $urandom_range(1, max_w);
		v = $urandom >> (32 - w);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic point_t rand_point();
		point_t p;
		case ($urandom_range(0, 9))
			0, 1: p = '{$urandom, $urandom, $urandom};
			2: p = '{32'(shx_q + radius_q), 32'(shy_q), 32'(shz_q + hlow_q) + rand_span(20)};
			3: p = '{32'(shx_q), 32'(shy_q), 32'(shz_q) + rand_span(26)};
			default: p = '{32'(shx_q) + rand_span(26), 32'(shy_q) + rand_span(26),
				32'(shz_q) + rand_span(26)};
		endcase
		return p;
	endfunction

	task automatic drain();
		while (pending_points.size() > 0 || sending || awaited_answers.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_points(int n);
		repeat (n) pending_points.push_back(rand_point());
	endtask

	task automatic random_cylinder();
		logic [31:0] lo;
		lo = rand_span(24);
		set_cylinder($urandom_range(0, 1 << 24), lo, lo + $urandom_range(0, 1 << 22),
			rand_span(28), rand_span(28), rand_span(28));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: unit radius, height 0 to 1.
		pending_points.push_back('{32'd0, 32'd0, 32'd0});
		pending_points.push_back('{32'd0, 32'd0, 32'd32768});
		pending_points.push_back('{32'd0, 32'd0, 32'd65536});
		pending_points.push_back('{32'd65536, 32'd0, 32'd32768});
		pending_points.push_back('{32'd65536, 32'd0, 32'd65536});
		pending_points.push_back('{32'd131072, 32'd0, 32'd32768});
		pending_points.push_back('{-32'sd196608, 32'd262144, 32'd32768});
		pending_points.push_back('{32'd32768, 32'd0, 32'd32768});
		pending_points.push_back('{32'd1, 32'd1, 32'd1});
		pending_points.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
		pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		pending_points.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'd0});
		pending_points.push_back('{32'd0, 32'd0, 32'h8000_0000});
		pending_points.push_back('{32'd0, 32'd40000, -32'sd5});
		random_points(220);
		drain();

		// Zero radius.
		set_cylinder(32'd0, -32'sd65536, 32'd65536, 32'd0, 32'd0, 32'd0);
		pending_points.push_back('{32'd0, 32'd0, 32'd0});
		pending_points.push_back('{32'd5, 32'd0, 32'd0});
		pending_points.push_back('{32'd0, 32'd0, 32'd200000});
		random_points(220);
		drain();

		// Extremes of every register but the z shift.
		set_cylinder(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'd12345);
		pending_points.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
		pending_points.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
		pending_points.push_back('{32'd0, 32'd0, 32'd0});
		random_points(220);
		drain();

		// Swapped heights: nothing lies inside.
		set_cylinder(32'd196608, 32'd327680, -32'sd327680, rand_span(20), rand_span(20), 32'd0);
		pending_points.push_back('{32'(shx_q), 32'(shy_q), 32'd0});
		random_points(220);
		drain();

		// Back to back with no idling on either side.
		random_cylinder();
		no_idle = 1'b1;
		random_points(220);
		drain();
		no_idle = 1'b0;

		// The receiver holds off long enough for the pipeline to fill.
		random_cylinder();
		hold_req = 1'b1;
		random_points(240);
		drain();

		random_cylinder();
		write_reg(REG_SPARE_6, $urandom);
		write_reg(REG_SPARE_7, $urandom);
		random_points(240);
		drain();

		random_cylinder();
		random_points(250);
		drain();

		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
